// ----- design/rsa_chunk_encrypt_decrypt_macros.svh -----
`ifndef RSA_CHUNK_ENCRYPT_DECRYPT_MACROS_SVH
`define RSA_CHUNK_ENCRYPT_DECRYPT_MACROS_SVH

// same-cycle implication, reset masks the check
`define RCE_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rce assertion failed");

// next-cycle implication
`define RCE_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rce assertion failed");

`endif

// ----- design/rce_pkg.sv -----
package rce_pkg;

  localparam int MOD_WIDTH = 32;
  localparam int REG_W     = 32;
  localparam int SRC_W     = 32;
  localparam int EXP_W     = 32;
  localparam int CHUNK_BYTES = 3;
  localparam int BYTE_BITS   = 8;
  localparam int CNT_W = $clog2((MOD_WIDTH > SRC_W) ? MOD_WIDTH : SRC_W);
  localparam int ECNT_W = $clog2(EXP_W);
  localparam int SUM_W = MOD_WIDTH + 2;

  localparam logic [1:0] REG_PUB_EXP  = 2'd0;
  localparam logic [1:0] REG_PRIV_EXP = 2'd1;
  localparam logic [1:0] REG_MODULUS  = 2'd2;

  localparam logic [REG_W-1:0] PUB_EXP_RESET  = 32'd65537;
  localparam logic [REG_W-1:0] PRIV_EXP_RESET = 32'd1;
  localparam logic [REG_W-1:0] MODULUS_RESET  = 32'd4294967291;

  typedef struct packed {
    logic       mode;
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
    logic [1:0] byte_count;
    logic [31:0] cipher_in;
  } rce_req_t;

  typedef struct packed {
    logic [31:0] cipher_out;
    logic [7:0]  plain_first;
    logic [7:0]  plain_second;
    logic [7:0]  plain_third;
    logic [1:0]  plain_count;
  } rce_rsp_t;

  localparam logic [3:0] OP_IDLE  = 4'd0;
  localparam logic [3:0] OP_RINIT = 4'd1;
  localparam logic [3:0] OP_RED   = 4'd2;
  localparam logic [3:0] OP_BSET  = 4'd3;
  localparam logic [3:0] OP_SQI   = 4'd4;
  localparam logic [3:0] OP_MUL   = 4'd5;
  localparam logic [3:0] OP_ACC   = 4'd6;
  localparam logic [3:0] OP_MULI  = 4'd7;
  localparam logic [3:0] OP_ESH   = 4'd8;
  localparam logic [3:0] OP_DONE  = 4'd9;

  localparam logic [2:0] JC_NEXT      = 3'd0;
  localparam logic [2:0] JC_ALWAYS    = 3'd1;
  localparam logic [2:0] JC_START_LOW = 3'd2;
  localparam logic [2:0] JC_CNT       = 3'd3;
  localparam logic [2:0] JC_ECNT      = 3'd4;
  localparam logic [2:0] JC_EXP_CLR   = 3'd5;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] S_RINIT = 4'd1;
  localparam logic [PC_W-1:0] S_RED   = 4'd2;
  localparam logic [PC_W-1:0] S_BSET  = 4'd3;
  localparam logic [PC_W-1:0] S_SQI   = 4'd4;
  localparam logic [PC_W-1:0] S_SQ    = 4'd5;
  localparam logic [PC_W-1:0] S_SQD   = 4'd6;
  localparam logic [PC_W-1:0] S_MULI  = 4'd7;
  localparam logic [PC_W-1:0] S_MUL   = 4'd8;
  localparam logic [PC_W-1:0] S_MULD  = 4'd9;
  localparam logic [PC_W-1:0] S_ESH   = 4'd10;
  localparam logic [PC_W-1:0] S_DONE  = 4'd11;

  typedef struct packed {
    logic [3:0]      op;
    logic [2:0]      jc;
    logic [PC_W-1:0] target;
  } rce_uword_t;

  typedef struct packed {
    logic [3:0] op;
  } rce_ctrl_t;

  typedef struct packed {
    logic cnt_nz;
    logic ecnt_nz;
    logic exp_top;
  } rce_stat_t;

  function automatic rce_uword_t ucode(input logic [PC_W-1:0] pc);
    rce_uword_t w;
    unique case (pc)
      S_IDLE:  w = '{op: OP_IDLE,  jc: JC_START_LOW, target: S_IDLE};
      S_RINIT: w = '{op: OP_RINIT, jc: JC_NEXT,      target: S_IDLE};
      S_RED:   w = '{op: OP_RED,   jc: JC_CNT,       target: S_RED};
      S_BSET:  w = '{op: OP_BSET,  jc: JC_NEXT,      target: S_IDLE};
      S_SQI:   w = '{op: OP_SQI,   jc: JC_NEXT,      target: S_IDLE};
      S_SQ:    w = '{op: OP_MUL,   jc: JC_CNT,       target: S_SQ};
      S_SQD:   w = '{op: OP_ACC,   jc: JC_EXP_CLR,   target: S_ESH};
      S_MULI:  w = '{op: OP_MULI,  jc: JC_NEXT,      target: S_IDLE};
      S_MUL:   w = '{op: OP_MUL,   jc: JC_CNT,       target: S_MUL};
      S_MULD:  w = '{op: OP_ACC,   jc: JC_NEXT,      target: S_IDLE};
      S_ESH:   w = '{op: OP_ESH,   jc: JC_ECNT,      target: S_SQI};
      S_DONE:  w = '{op: OP_DONE,  jc: JC_ALWAYS,    target: S_IDLE};
      default: w = '{op: OP_DONE,  jc: JC_ALWAYS,    target: S_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [MOD_WIDTH-1:0] to_mw(input logic [REG_W-1:0] v);
    logic [MOD_WIDTH-1:0] r;
    for (int i = 0; i < MOD_WIDTH; i++) begin
      r[i] = (i < REG_W) ? v[i] : 1'b0;
    end
    return r;
  endfunction

  function automatic logic [REG_W-1:0] from_mw(input logic [MOD_WIDTH-1:0] v);
    logic [REG_W-1:0] r;
    for (int i = 0; i < REG_W; i++) begin
      r[i] = (i < MOD_WIDTH) ? v[i] : 1'b0;
    end
    return r;
  endfunction

  // (2r + (b ? a : 0)) mod n, r and a below n; sum stays below 3n
  function automatic logic [MOD_WIDTH-1:0] mod_step(input logic [MOD_WIDTH-1:0] r,
                                                    input logic b,
                                                    input logic [MOD_WIDTH-1:0] a,
                                                    input logic [MOD_WIDTH-1:0] n);
    logic [SUM_W-1:0] t;
    logic [SUM_W-1:0] n1;
    logic [SUM_W-1:0] n2;
    logic [SUM_W-1:0] s;
    t  = {1'b0, r, 1'b0} + (b ? {2'b00, a} : '0);
    n1 = {2'b00, n};
    n2 = {1'b0, n, 1'b0};
    if (t >= n2) begin
      s = t - n2;
    end else if (t >= n1) begin
      s = t - n1;
    end else begin
      s = t;
    end
    return s[MOD_WIDTH-1:0];
  endfunction

endpackage

// ----- design/rce_datapath.sv -----
module rce_datapath import rce_pkg::*; (
  input  logic             clk,
  input  rce_ctrl_t        ctrl,
  input  rce_req_t         req,
  input  logic [REG_W-1:0] pub_exp,
  input  logic [REG_W-1:0] priv_exp,
  input  logic [REG_W-1:0] modulus,
  output rce_stat_t        stat,
  output rce_rsp_t         rsp
);

  logic [MOD_WIDTH-1:0] n;
  logic [SRC_W-1:0]     src;
  logic [EXP_W-1:0]     exp;
  logic                 mode;
  logic [MOD_WIDTH-1:0] r;
  logic [MOD_WIDTH-1:0] a;
  logic [MOD_WIDTH-1:0] y;
  logic [MOD_WIDTH-1:0] base;
  logic [MOD_WIDTH-1:0] acc;
  logic [CNT_W-1:0]     cnt;
  logic [ECNT_W-1:0]    ecnt;
  logic [SRC_W-1:0]     msg;
  logic [REG_W-1:0]     p;

  assign n = to_mw(modulus);

  always_comb begin
    msg = '0;
    if (req.byte_count >= 2'd1) msg[BYTE_BITS-1:0] = req.byte_first;
    if (req.byte_count >= 2'd2) msg[2*BYTE_BITS-1:BYTE_BITS] = req.byte_second;
    if (req.byte_count >= 2'(CHUNK_BYTES)) begin
      msg[3*BYTE_BITS-1:2*BYTE_BITS] = req.byte_third;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_IDLE: begin
        mode <= req.mode;
        src  <= req.mode ? req.cipher_in : msg;
        exp  <= req.mode ? priv_exp : pub_exp;
      end
      OP_RINIT: begin
        r   <= '0;
        cnt <= CNT_W'(SRC_W - 1);
      end
      OP_RED: begin
        r   <= mod_step(r, src[SRC_W-1], MOD_WIDTH'(1), n);
        src <= src << 1;
        cnt <= cnt - 1'b1;
      end
      OP_BSET: begin
        base <= r;
        acc  <= (n == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
        ecnt <= ECNT_W'(EXP_W - 1);
      end
      OP_SQI: begin
        a   <= acc;
        y   <= acc;
        r   <= '0;
        cnt <= CNT_W'(MOD_WIDTH - 1);
      end
      OP_MUL: begin
        r   <= mod_step(r, y[MOD_WIDTH-1], a, n);
        y   <= y << 1;
        cnt <= cnt - 1'b1;
      end
      OP_ACC: begin
        acc <= r;
      end
      OP_MULI: begin
        a   <= base;
        y   <= acc;
        r   <= '0;
        cnt <= CNT_W'(MOD_WIDTH - 1);
      end
      OP_ESH: begin
        exp  <= exp << 1;
        ecnt <= ecnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign stat.cnt_nz  = (cnt != '0);
  assign stat.ecnt_nz = (ecnt != '0);
  assign stat.exp_top = exp[EXP_W-1];

  // no valid modulus: result is zero
  assign p = (n == '0) ? '0 : from_mw(acc);

  always_comb begin
    rsp = '0;
    if (!mode) begin
      rsp.cipher_out = p;
    end else begin
      rsp.plain_first  = p[BYTE_BITS-1:0];
      rsp.plain_second = p[2*BYTE_BITS-1:BYTE_BITS];
      rsp.plain_third  = p[3*BYTE_BITS-1:2*BYTE_BITS];
      if (rsp.plain_third != '0) begin
        rsp.plain_count = 2'(CHUNK_BYTES);
      end else if (rsp.plain_second != '0) begin
        rsp.plain_count = 2'd2;
      end else begin
        rsp.plain_count = 2'd1;
      end
    end
  end

endmodule

// ----- design/rce_sequencer.sv -----
`include "rsa_chunk_encrypt_decrypt_macros.svh"

module rce_sequencer import rce_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  rce_stat_t stat,
  output rce_ctrl_t ctrl,
  output logic      busy,
  output logic      done
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  rce_uword_t      uw;

  assign uw = ucode(pc);

  always_comb begin
    unique case (uw.jc)
      JC_NEXT:      pc_next = pc + 1'b1;
      JC_ALWAYS:    pc_next = uw.target;
      JC_START_LOW: pc_next = start ? pc + 1'b1 : uw.target;
      JC_CNT:       pc_next = stat.cnt_nz ? uw.target : pc + 1'b1;
      JC_ECNT:      pc_next = stat.ecnt_nz ? uw.target : pc + 1'b1;
      JC_EXP_CLR:   pc_next = stat.exp_top ? pc + 1'b1 : uw.target;
      default:      pc_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.op = uw.op;
  assign busy    = (pc != S_IDLE);
  assign done    = (uw.op == OP_DONE);

  `RCE_ASSERT_NEXT(a_accept_starts, start && !busy, pc == S_RINIT)
  `RCE_ASSERT_NEXT(a_done_returns, done, pc == S_IDLE && !done)
  `RCE_ASSERT_NEXT(a_reduce_exit, pc == S_RED && !stat.cnt_nz, pc == S_BSET)
  `RCE_ASSERT_NOW(a_idle_not_done, !busy, !done)

endmodule

// ----- design/rsa_chunk_encrypt_decrypt.sv -----
// channel   ports                              handshake
// request   req (rce_req_t)                    start & !busy
// result    rsp (rce_rsp_t)                    done, one cycle, no backpressure
// config    cfg_we, cfg_addr, cfg_data         cfg_we
//
// Each transaction reduces the source modulo the modulus, then for every exponent bit from
// the top squares the accumulator and, for a set bit, multiplies it by the base, each product
// formed by the bit-serial modular multiplier. A new request is taken only while idle.
// Reset clears the step counter and returns config registers to reset values; datapath registers are not reset.
// The receiver cannot stall; results show for one cycle with done.
module rsa_chunk_encrypt_decrypt import rce_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rce_req_t         req,
  output logic             done,
  output rce_rsp_t         rsp,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [REG_W-1:0] cfg_data
);

  logic [REG_W-1:0] pub_exp;
  logic [REG_W-1:0] priv_exp;
  logic [REG_W-1:0] modulus;
  rce_ctrl_t        ctrl;
  rce_stat_t        stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      pub_exp  <= PUB_EXP_RESET;
      priv_exp <= PRIV_EXP_RESET;
      modulus  <= MODULUS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PUB_EXP:  pub_exp  <= cfg_data;
        REG_PRIV_EXP: priv_exp <= cfg_data;
        REG_MODULUS:  modulus  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rce_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (done)
  );

  rce_datapath u_dp (
    .clk      (clk),
    .ctrl     (ctrl),
    .req      (req),
    .pub_exp  (pub_exp),
    .priv_exp (priv_exp),
    .modulus  (modulus),
    .stat     (stat),
    .rsp      (rsp)
  );

endmodule

// ----- test/rsa_chunk_encrypt_decrypt_tb.sv -----
`timescale 1ns / 100ps

module rsa_chunk_encrypt_decrypt_tb;
  import rce_pkg::*;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  typedef enum logic [1:0] {JOB_CHUNK, JOB_REG_WRITE, JOB_DRAIN} job_kind_t;

  typedef struct {
    job_kind_t        kind;
    rce_req_t         chunk;
    logic [1:0]       addr;
    logic [REG_W-1:0] data;
    int               gap;
  } job_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  rce_req_t         req;
  logic             done;
  rce_rsp_t         rsp;
  logic             cfg_we;
  logic [1:0]       cfg_addr;
  logic [REG_W-1:0] cfg_data;

  job_t     chunk_jobs[$];
  rce_rsp_t results_due[$];

  logic [REG_W-1:0] key_pub;
  logic [REG_W-1:0] key_priv;
  logic [REG_W-1:0] key_mod;

  logic req_taken;
  int   gap_left;
  int   error_count;
  bit   calm;

  rsa_chunk_encrypt_decrypt dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] mod_power(logic [31:0] base, logic [31:0] e,
                                            logic [31:0] n);
    longint unsigned acc;
    longint unsigned b;
    longint unsigned m;
    if (n == 0) return 32'd0;
    m   = n;
    b   = base % m;
    acc = 1 % m;
    for (int i = 31; i >= 0; i--) begin
      acc = (acc * acc) % m;
      if (e[i]) acc = (acc * b) % m;
    end
    return acc[31:0];
  endfunction

  function automatic rce_rsp_t chunk_result(rce_req_t r);
    rce_rsp_t    o;
    logic [31:0] msg;
    logic [31:0] p;
    o = '0;
    if (r.mode == MODE_ENCRYPT) begin
      case (r.byte_count)
        2'd1:    msg = {24'd0, r.byte_first};
        2'd2:    msg = {16'd0, r.byte_second, r.byte_first};
        2'd3:    msg = {8'd0, r.byte_third, r.byte_second, r.byte_first};
        default: msg = 32'd0;
      endcase
      o.cipher_out = mod_power(msg, key_pub, key_mod);
    end else begin
      p = mod_power(r.cipher_in, key_priv, key_mod);
      o.plain_first  = p[7:0];
      o.plain_second = p[15:8];
      o.plain_third  = p[23:16];
      if (p[23:16] != 0)     o.plain_count = 2'd3;
      else if (p[15:8] != 0) o.plain_count = 2'd2;
      else                   o.plain_count = 2'd1;
    end
    return o;
  endfunction

  task automatic log_error(string msg);
    error_count++;
    $display("%0t ERROR %s", $realtime, msg);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(1500, 2600);
  endfunction

  function automatic logic [31:0] pick_exp();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'd65537;
      4:       return 32'd3;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_mod();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 2);
      1:       return $urandom_range(3, 32'h0100_0000);
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom_range(32'h0100_0001, 32'hFFFF_FFFF);
      default: return $urandom | 32'h8000_0000;
    endcase
  endfunction

  function automatic rce_req_t enc_req(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                       logic [1:0] cnt);
    rce_req_t r;
    r.mode        = MODE_ENCRYPT;
    r.byte_first  = b0;
    r.byte_second = b1;
    r.byte_third  = b2;
    r.byte_count  = cnt;
    r.cipher_in   = $urandom;
    return r;
  endfunction

  function automatic rce_req_t dec_req(logic [31:0] cin);
    rce_req_t r;
    r.mode        = MODE_DECRYPT;
    r.byte_first  = 8'($urandom);
    r.byte_second = 8'($urandom);
    r.byte_third  = 8'($urandom);
    r.byte_count  = 2'($urandom);
    r.cipher_in   = cin;
    return r;
  endfunction

  function automatic rce_req_t random_chunk();
    logic [31:0] cin;
    case ($urandom_range(0, 3))
      0:       cin = $urandom;
      1:       cin = $urandom_range(0, 255) << (8 * $urandom_range(0, 2));
      2:       cin = $urandom & 32'h00FF_FFFF;
      default: cin = 32'hFFFF_FFFF - $urandom_range(0, 15);
    endcase
    if ($urandom_range(0, 1) == 0) return dec_req(cin);
    return enc_req(8'($urandom), 8'($urandom), 8'($urandom),
                   ($urandom_range(0, 15) == 0) ? 2'd0 : 2'($urandom_range(1, 3)));
  endfunction

  task automatic push_chunk(rce_req_t r);
    job_t j;
    j.kind  = JOB_CHUNK;
    j.chunk = r;
    j.addr  = '0;
    j.data  = '0;
    j.gap   = calm ? 0 : pick_gap();
    chunk_jobs.push_back(j);
  endtask

  task automatic push_reg(logic [1:0] a, logic [REG_W-1:0] d);
    job_t j;
    j.kind  = JOB_REG_WRITE;
    j.chunk = '0;
    j.addr  = a;
    j.data  = d;
    j.gap   = 0;
    chunk_jobs.push_back(j);
  endtask

  task automatic push_drain();
    job_t j;
    j.kind  = JOB_DRAIN;
    j.chunk = '0;
    j.addr  = '0;
    j.data  = '0;
    j.gap   = 0;
    chunk_jobs.push_back(j);
  endtask

  // driver: one nonblocking update per signal per negedge
  always @(negedge clk) begin : drive
    job_t head;
    logic nxt_start;
    logic nxt_we;
    nxt_start = start;
    nxt_we    = 1'b0;
    if (rst) begin
      nxt_start = 1'b0;
    end else if (!start || req_taken) begin
      req_taken = 1'b0;
      nxt_start = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (chunk_jobs.size() != 0) begin
        head = chunk_jobs[0];
        case (head.kind)
          JOB_CHUNK: begin
            nxt_start = 1'b1;
            req      <= head.chunk;
            gap_left  = head.gap;
            void'(chunk_jobs.pop_front());
          end
          JOB_REG_WRITE: begin
            if (results_due.size() == 0 && busy === 1'b0) begin
              nxt_we    = 1'b1;
              cfg_addr <= head.addr;
              cfg_data <= head.data;
              case (head.addr)
                REG_PUB_EXP:  key_pub  = head.data;
                REG_PRIV_EXP: key_priv = head.data;
                REG_MODULUS:  key_mod  = head.data;
                default: ;
              endcase
              void'(chunk_jobs.pop_front());
            end
          end
          JOB_DRAIN: begin
            if (results_due.size() == 0) void'(chunk_jobs.pop_front());
          end
          default: ;
        endcase
      end
    end
    start  <= nxt_start;
    cfg_we <= nxt_we;
  end

  // monitor: results first, then the transaction taken at this edge
  always @(posedge clk) begin : observe
    rce_rsp_t want;
    string    diff;
    if (!rst && done === 1'b1) begin
      if (results_due.size() == 0) begin
        log_error($sformatf("result with nothing outstanding: %h", rsp));
      end else begin
        want = results_due.pop_front();
        diff = "";
        if (rsp.cipher_out !== want.cipher_out)
          diff = {diff, $sformatf(" cipher_out %h/%h", rsp.cipher_out, want.cipher_out)};
        if (rsp.plain_first !== want.plain_first)
          diff = {diff, $sformatf(" plain_first %h/%h", rsp.plain_first, want.plain_first)};
        if (rsp.plain_second !== want.plain_second)
          diff = {diff, $sformatf(" plain_second %h/%h", rsp.plain_second,
                                  want.plain_second)};
        if (rsp.plain_third !== want.plain_third)
          diff = {diff, $sformatf(" plain_third %h/%h", rsp.plain_third, want.plain_third)};
        if (rsp.plain_count !== want.plain_count)
          diff = {diff, $sformatf(" plain_count %0d/%0d", rsp.plain_count, want.plain_count)};
        if (diff != "") log_error({"chunk mismatch (got/exp):", diff});
      end
    end
    if (!rst && start === 1'b1 && busy === 1'b0) begin
      results_due.push_back(chunk_result(req));
      req_taken = 1'b1;
    end
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    req         = '0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_data    = '0;
    req_taken   = 1'b0;
    gap_left    = 0;
    error_count = 0;
    calm        = 1'b0;
    key_pub     = PUB_EXP_RESET;
    key_priv    = PRIV_EXP_RESET;
    key_mod     = MODULUS_RESET;

    // reset keys: byte packing, ignored bytes, empty chunk, plain byte counts
    push_chunk(enc_req(8'h00, 8'h00, 8'h00, 2'd1));
    push_chunk(enc_req(8'hFF, 8'hFF, 8'hFF, 2'd3));
    push_chunk(enc_req(8'h01, 8'h80, 8'h7F, 2'd2));
    push_chunk(enc_req(8'hFF, 8'hFF, 8'hFF, 2'd0));
    push_chunk(enc_req(8'hAA, 8'h55, 8'hFF, 2'd1));
    push_chunk(dec_req(32'h0000_0000));
    push_chunk(dec_req(32'hFFFF_FFFF));
    push_chunk(dec_req(MODULUS_RESET));
    push_chunk(dec_req(32'h0000_00AB));
    push_chunk(dec_req(32'h0000_AB00));
    push_chunk(dec_req(32'h00AB_0000));
    push_chunk(dec_req(32'h00FF_FFFF));
    push_chunk(dec_req(32'h1234_5678));

    // zero exponents
    push_drain();
    push_reg(REG_PUB_EXP, 32'd0);
    push_reg(REG_PRIV_EXP, 32'd0);
    push_chunk(enc_req(8'h12, 8'h34, 8'h56, 2'd3));
    push_chunk(dec_req(32'hFFFF_FFFF));

    // degenerate moduli
    push_reg(REG_MODULUS, 32'd1);
    push_chunk(enc_req(8'h12, 8'h34, 8'h56, 2'd3));
    push_chunk(dec_req(32'h0000_0001));
    push_reg(REG_MODULUS, 32'd0);
    push_chunk(enc_req(8'hFF, 8'h00, 8'h01, 2'd3));
    push_chunk(dec_req(32'h0000_0005));

    // all-ones keys
    push_reg(REG_MODULUS, 32'hFFFF_FFFF);
    push_reg(REG_PUB_EXP, 32'hFFFF_FFFF);
    push_reg(REG_PRIV_EXP, 32'hFFFF_FFFF);
    push_chunk(enc_req(8'hFF, 8'hFF, 8'hFF, 2'd3));
    push_chunk(dec_req(32'hFFFF_FFFE));
    push_chunk(dec_req(32'hFFFF_FFFF));

    // modulus far below 2^24
    push_reg(REG_MODULUS, 32'd2);
    push_chunk(enc_req(8'h03, 8'h00, 8'h00, 2'd1));
    push_chunk(dec_req(32'h0000_0005));

    for (int ph = 0; ph < 10; ph++) begin
      push_drain();
      calm = (ph % 3 == 1);
      if ($urandom_range(0, 2) != 0) push_reg(REG_PUB_EXP, pick_exp());
      if ($urandom_range(0, 2) != 0) push_reg(REG_PRIV_EXP, pick_exp());
      if ($urandom_range(0, 2) != 0) push_reg(REG_MODULUS, pick_mod());
      repeat (27) push_chunk(random_chunk());
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (chunk_jobs.size() != 0 || start) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (2400) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/rce_pkg.sv
design/rce_datapath.sv
design/rce_sequencer.sv
design/rsa_chunk_encrypt_decrypt.sv
test/rsa_chunk_encrypt_decrypt_tb.sv
